### design/opke_pkg.sv
package opke_pkg;

  // Column type codes
  localparam logic [3:0] COL_I8      = 4'd0;
  localparam logic [3:0] COL_I16     = 4'd1;
  localparam logic [3:0] COL_I32     = 4'd2;
  localparam logic [3:0] COL_I64     = 4'd3;
  localparam logic [3:0] COL_U64     = 4'd4;
  localparam logic [3:0] COL_BOOL    = 4'd5;
  localparam logic [3:0] COL_DATE    = 4'd6;
  localparam logic [3:0] COL_TS      = 4'd7;
  localparam logic [3:0] COL_DEC     = 4'd8;
  localparam logic [3:0] COL_WIDE    = 4'd9;
  localparam logic [3:0] COL_CHAR    = 4'd10;
  localparam logic [3:0] COL_VARCHAR = 4'd11;
  localparam logic [3:0] COL_FLOAT   = 4'd12;

  // Value kind codes
  localparam logic [2:0] VK_INT  = 3'd0;
  localparam logic [2:0] VK_STR  = 3'd1;
  localparam logic [2:0] VK_DEC  = 3'd2;
  localparam logic [2:0] VK_WIDE = 3'd3;
  localparam logic [2:0] VK_NULL = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_KIND    = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_FLOAT   = 3'd3;
  localparam logic [2:0] ST_NULL    = 3'd4;
  localparam logic [2:0] ST_ZERO    = 3'd5;
  localparam logic [2:0] ST_SCALE   = 3'd6;
  localparam logic [2:0] ST_UNKNOWN = 3'd7;

  // Mark byte plus up to 16 value bytes
  localparam int unsigned KEY_BUF_BYTES = 17;
  localparam int unsigned KEY_CNT_W     = 5;

  // One decoded item: left-aligned key bytes, then optional zero padding
  typedef struct packed {
    logic [8*KEY_BUF_BYTES-1:0] key_bytes;
    logic [KEY_CNT_W-1:0]       key_cnt;
    logic [2:0]                 status;
    logic                       done;
  } job_t;

endpackage

### design/opke_front.sv
module opke_front import opke_pkg::*; #(
  parameter int unsigned STRING_KEY_BYTES = 32,
  parameter int unsigned PW = $clog2(STRING_KEY_BYTES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         present_mark_i,
  input  logic [3:0]         col_type_i,
  input  logic [15:0]        col_len_i,
  input  logic [7:0]         col_scale_i,
  input  logic [2:0]         val_kind_i,
  input  logic [7:0]         val_scale_i,
  input  logic signed [63:0] val_low_i,
  input  logic signed [63:0] val_high_i,
  input  logic [7:0]         str_byte_i,
  input  logic               str_last_i,
  input  logic               str_empty_i,
  output job_t               job_o,
  output logic [PW-1:0]      pad_cnt_o,
  output logic               has_job_o
);

  logic          in_string_q, in_string_d;
  logic          skipping_q, skipping_d;
  logic [PW-1:0] str_pos_q, str_pos_d;
  logic [PW-1:0] str_width_q, str_width_d;

  logic          follows;
  logic [PW-1:0] char_width;
  logic [63:0]   lo;
  logic [63:0]   hi;

  always_comb begin
    follows = (val_kind_i == VK_STR) && !str_last_i;
    char_width = (col_len_i < 16'(STRING_KEY_BYTES)) ? col_len_i[PW-1:0]
                                                     : PW'(STRING_KEY_BYTES);
    lo = val_low_i;
    hi = val_high_i;
  end

  // Item decode and string tracking
  always_comb begin
    logic          fail;
    logic [2:0]    fail_st;
    logic          fail_fol;
    logic          feed;
    logic          start;
    logic [PW-1:0] pos_in;
    logic [PW-1:0] wid_in;
    logic          put;
    logic [PW-1:0] pos1;
    logic [127:0]  data;

    fail     = 1'b0;
    fail_st  = ST_OK;
    fail_fol = 1'b0;
    feed     = 1'b0;
    start    = 1'b0;
    pos_in   = str_pos_q;
    wid_in   = str_width_q;
    put      = 1'b0;
    pos1     = '0;
    data     = '0;

    job_o       = '0;
    pad_cnt_o   = '0;
    in_string_d = in_string_q;
    skipping_d  = skipping_q;
    str_pos_d   = str_pos_q;
    str_width_d = str_width_q;

    if (in_string_q) begin
      if (skipping_q) begin
        if (str_last_i) begin
          in_string_d = 1'b0;
          skipping_d  = 1'b0;
        end
      end else begin
        feed = 1'b1;
      end
    end else begin
      // type checks
      case (col_type_i) inside
        COL_FLOAT: begin
          fail = 1'b1; fail_st = ST_FLOAT; fail_fol = follows;
        end
        COL_CHAR: begin
          if (char_width == '0) begin
            fail = 1'b1; fail_st = ST_ZERO; fail_fol = follows;
          end
        end
        COL_I8, COL_I16, COL_I32, COL_I64, COL_U64, COL_BOOL, COL_DATE, COL_TS,
        COL_DEC, COL_WIDE, COL_VARCHAR: begin
        end
        default: begin
          fail = 1'b1; fail_st = ST_UNKNOWN; fail_fol = follows;
        end
      endcase

      if (!fail && val_kind_i == VK_NULL) begin
        fail = 1'b1; fail_st = ST_NULL; fail_fol = 1'b0;
      end

      // value checks and byte layout
      if (!fail) begin
        case (col_type_i) inside
          COL_I8: begin
            if (val_kind_i != VK_INT) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else if (!((&lo[63:7]) || !(|lo[63:7]))) begin
              fail = 1'b1; fail_st = ST_RANGE;
            end else begin
              data = {~lo[7], lo[6:0], 120'd0};
              job_o.key_cnt = KEY_CNT_W'(2);
            end
          end
          COL_I16: begin
            if (val_kind_i != VK_INT) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else if (!((&lo[63:15]) || !(|lo[63:15]))) begin
              fail = 1'b1; fail_st = ST_RANGE;
            end else begin
              data = {~lo[15], lo[14:0], 112'd0};
              job_o.key_cnt = KEY_CNT_W'(3);
            end
          end
          COL_I32, COL_DATE: begin
            if (val_kind_i != VK_INT) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else if (!((&lo[63:31]) || !(|lo[63:31]))) begin
              fail = 1'b1; fail_st = ST_RANGE;
            end else begin
              data = {~lo[31], lo[30:0], 96'd0};
              job_o.key_cnt = KEY_CNT_W'(5);
            end
          end
          COL_I64, COL_TS: begin
            if (val_kind_i != VK_INT) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else begin
              data = {~lo[63], lo[62:0], 64'd0};
              job_o.key_cnt = KEY_CNT_W'(9);
            end
          end
          COL_BOOL: begin
            if (val_kind_i != VK_INT || (|lo[63:1])) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else begin
              data = {lo[7:0], 120'd0};
              job_o.key_cnt = KEY_CNT_W'(2);
            end
          end
          COL_U64: begin
            if (val_kind_i != VK_INT) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else begin
              data = {lo, 64'd0};
              job_o.key_cnt = KEY_CNT_W'(9);
            end
          end
          COL_DEC: begin
            if (val_kind_i != VK_DEC) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else if (val_scale_i != col_scale_i) begin
              fail = 1'b1; fail_st = ST_SCALE;
            end else begin
              data = {~lo[63], lo[62:0], 64'd0};
              job_o.key_cnt = KEY_CNT_W'(9);
            end
          end
          COL_WIDE: begin
            if (val_kind_i != VK_WIDE) begin
              fail = 1'b1; fail_st = ST_KIND; fail_fol = follows;
            end else if (val_scale_i != col_scale_i) begin
              fail = 1'b1; fail_st = ST_SCALE;
            end else begin
              data = {~hi[63], hi[62:0], lo};
              job_o.key_cnt = KEY_CNT_W'(17);
            end
          end
          default: begin
            // char and varchar
            if (val_kind_i != VK_STR) begin
              fail = 1'b1; fail_st = ST_KIND;
            end else begin
              feed   = 1'b1;
              start  = 1'b1;
              pos_in = '0;
              wid_in = (col_type_i == COL_CHAR) ? char_width : PW'(STRING_KEY_BYTES);
              str_width_d = wid_in;
            end
          end
        endcase
      end

      job_o.key_bytes = {present_mark_i, data};
      job_o.done      = 1'b1;
    end

    // one string byte, padding and truncation
    if (feed) begin
      put  = !str_empty_i && (pos_in < wid_in);
      pos1 = pos_in + PW'(put);
      if (start) begin
        job_o.key_bytes = {present_mark_i, str_byte_i, 120'd0};
        job_o.key_cnt   = KEY_CNT_W'(put) + KEY_CNT_W'(1);
      end else begin
        job_o.key_bytes = {str_byte_i, 128'd0};
        job_o.key_cnt   = KEY_CNT_W'(put);
      end
      if (str_last_i) begin
        pad_cnt_o   = wid_in - pos1;
        str_pos_d   = wid_in;
        job_o.done  = 1'b1;
        in_string_d = 1'b0;
        skipping_d  = 1'b0;
      end else if (pos1 >= wid_in) begin
        str_pos_d   = pos1;
        job_o.done  = 1'b1;
        in_string_d = 1'b1;
        skipping_d  = 1'b1;
      end else begin
        str_pos_d   = pos1;
        job_o.done  = 1'b0;
        in_string_d = 1'b1;
        skipping_d  = 1'b0;
      end
    end

    // error: a single zero byte with status
    if (fail) begin
      job_o.key_bytes = '0;
      job_o.key_cnt   = KEY_CNT_W'(1);
      job_o.status    = fail_st;
      job_o.done      = 1'b1;
      pad_cnt_o       = '0;
      if (fail_fol) begin
        in_string_d = 1'b1;
        skipping_d  = 1'b1;
      end
    end

    has_job_o = (job_o.key_cnt != '0) || (pad_cnt_o != '0);
  end

  // String state advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      skipping_q  <= 1'b0;
      str_pos_q   <= '0;
      str_width_q <= '0;
    end else if (accept_i) begin
      in_string_q <= in_string_d;
      skipping_q  <= skipping_d;
      str_pos_q   <= str_pos_d;
      str_width_q <= str_width_d;
    end
  end

endmodule

### design/opke_serial.sv
module opke_serial import opke_pkg::*; #(
  parameter int unsigned PW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  job_t          job_i,
  input  logic [PW-1:0] pad_cnt_i,
  input  logic          has_job_i,
  output logic          busy_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [7:0]    key_byte_o,
  output logic [2:0]    status_o,
  output logic          last_o
);

  localparam int unsigned KW = 8 * KEY_BUF_BYTES;

  logic                 job_valid_q;
  logic [KW-1:0]        key_q;
  logic [KEY_CNT_W-1:0] key_left_q;
  logic [PW-1:0]        pad_left_q;
  logic [2:0]           status_q;
  logic                 done_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [2:0] out_status_q;
  logic       out_last_q;

  logic out_free;
  logic beat;
  logic final_beat;

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    beat       = job_valid_q && out_free;
    final_beat = ((key_left_q == KEY_CNT_W'(1)) && (pad_left_q == '0)) ||
                 ((key_left_q == '0) && (pad_left_q == PW'(1)));
    // the next item may enter as the current one sends its final byte
    busy_o     = job_valid_q && !(beat && final_beat);
  end

  // Active job: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      key_left_q  <= '0;
      pad_left_q  <= '0;
    end else if (load_i) begin
      job_valid_q <= has_job_i;
      key_left_q  <= job_i.key_cnt;
      pad_left_q  <= pad_cnt_i;
    end else if (beat) begin
      if (final_beat) begin
        job_valid_q <= 1'b0;
      end
      if (key_left_q != '0) begin
        key_left_q <= key_left_q - KEY_CNT_W'(1);
      end else begin
        pad_left_q <= pad_left_q - PW'(1);
      end
    end
  end

  // Active job: key bytes shift out from the top
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q    <= job_i.key_bytes;
      status_q <= job_i.status;
      done_q   <= job_i.done;
    end else if (beat) begin
      key_q <= {key_q[KW-9:0], 8'd0};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      out_byte_q   <= (key_left_q != '0) ? key_q[KW-1 -: 8] : 8'd0;
      out_status_q <= status_q;
      out_last_q   <= final_beat && done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_byte_o  = out_byte_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule

### design/order_preserving_key_encoder.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    one column value or one string byte
// out       output     out_valid_o / out_stall_i  key_byte_o, status_o, last_o
// cfg       input      cfg_wr_en_i                cfg_wr_data_i (present mark)
//
// One key byte leaves per cycle while the output does not stall; the next item
// waits at the input until the active job sends its final key byte, and an item
// with no bytes leaves no active job. The first byte passes through the job
// register, then the output register. The shift register of the active job sets the rate.
// Reset sets the present mark to 1 and leaves no string open.
// A stall on the output holds the output register; the input stalls only
// while the active job still has bytes to send.
module order_preserving_key_encoder import opke_pkg::*; #(
  parameter int unsigned STRING_KEY_BYTES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         col_type_i,
  input  logic [15:0]        col_len_i,
  input  logic [7:0]         col_scale_i,
  input  logic [2:0]         val_kind_i,
  input  logic [7:0]         val_scale_i,
  input  logic signed [63:0] val_low_i,
  input  logic signed [63:0] val_high_i,
  input  logic [7:0]         str_byte_i,
  input  logic               str_last_i,
  input  logic               str_empty_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         key_byte_o,
  output logic [2:0]         status_o,
  output logic               last_o,
  input  logic               cfg_wr_en_i,
  input  logic [7:0]         cfg_wr_data_i
);

  localparam int unsigned PW = $clog2(STRING_KEY_BYTES + 1);

  logic [7:0]    present_mark_q;
  logic          accept;
  logic          busy;
  job_t          job;
  logic [PW-1:0] pad_cnt;
  logic          has_job;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  // Present mark register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_mark_q <= 8'd1;
    end else if (cfg_wr_en_i) begin
      present_mark_q <= cfg_wr_data_i;
    end
  end

  opke_front #(
    .STRING_KEY_BYTES(STRING_KEY_BYTES),
    .PW              (PW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .present_mark_i(present_mark_q),
    .col_type_i    (col_type_i),
    .col_len_i     (col_len_i),
    .col_scale_i   (col_scale_i),
    .val_kind_i    (val_kind_i),
    .val_scale_i   (val_scale_i),
    .val_low_i     (val_low_i),
    .val_high_i    (val_high_i),
    .str_byte_i    (str_byte_i),
    .str_last_i    (str_last_i),
    .str_empty_i   (str_empty_i),
    .job_o         (job),
    .pad_cnt_o     (pad_cnt),
    .has_job_o     (has_job)
  );

  opke_serial #(
    .PW(PW)
  ) u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .job_i      (job),
    .pad_cnt_i  (pad_cnt),
    .has_job_i  (has_job),
    .busy_o     (busy),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .key_byte_o (key_byte_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

endmodule
